/* sv/sbct_pkg.sv */
// Shared types, constants and helpers for the swept box collision time block.
// Used by sbct_div_cell and swept_box_collision_time.
`timescale 1ns / 1ps
`default_nettype none

package sbct_pkg;

  localparam int DW = 32;            // divisor and time width
  localparam int NW = 49;            // numerator magnitude width (gap << 16)
  localparam int NSTEP = NW;         // one quotient bit per cell

  localparam logic [2:0] SIDE_NONE   = 3'd0;
  localparam logic [2:0] SIDE_LEFT   = 3'd1;
  localparam logic [2:0] SIDE_RIGHT  = 3'd2;
  localparam logic [2:0] SIDE_TOP    = 3'd3;
  localparam logic [2:0] SIDE_BOTTOM = 3'd4;

  localparam logic signed [DW-1:0] TIME_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] TIME_MAX = {1'b0, {(DW-1){1'b1}}};

  typedef struct packed {
    logic [DW-1:0] rem;   // partial remainder
    logic [NW-1:0] nq;    // numerator bits shift out, quotient bits shift in
    logic [DW-1:0] d;     // divisor magnitude
    logic          neg;   // quotient sign
  } div_t;

  typedef struct packed {
    logic x_pos;
    logic x_neg;
    logic x_ovl;
    logic y_pos;
    logic y_neg;
    logic y_ovl;
  } info_t;

  // Apply the sign to a quotient magnitude and saturate to the time range.
  function automatic logic signed [DW-1:0] sat_time(input logic [NW-1:0] q, input logic neg);
    logic [NW-1:0] nq;
    nq = ~q + {{(NW-1){1'b0}}, 1'b1};
    if (neg) begin
      if (q > {{(NW-DW){1'b0}}, TIME_MIN}) sat_time = TIME_MIN;
      else sat_time = nq[DW-1:0];
    end else begin
      if (q > {{(NW-DW){1'b0}}, TIME_MAX}) sat_time = TIME_MAX;
      else sat_time = q[DW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* sv/sbct_div_cell.sv */
// One restoring division step: produces one quotient bit per cycle while en_i is high.
// Depends on sbct_pkg for the div_t data word.
`timescale 1ns / 1ps
`default_nettype none

module sbct_div_cell
  import sbct_pkg::*;
(
  input  wire  clk_i,
  input  wire  en_i,
  input  div_t dat_i,
  output div_t dat_o
);

  div_t dat_q, dat_d;
  logic [DW:0] trial;
  logic [DW:0] diff;

  always_comb begin
    trial = {dat_i.rem, dat_i.nq[NW-1]};
    diff  = trial - {1'b0, dat_i.d};
    dat_d = dat_i;
    if (trial >= {1'b0, dat_i.d}) begin
      dat_d.rem = diff[DW-1:0];
      dat_d.nq  = {dat_i.nq[NW-2:0], 1'b1};
    end else begin
      dat_d.rem = trial[DW-1:0];
      dat_d.nq  = {dat_i.nq[NW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) dat_q <= dat_d;
  end

  assign dat_o = dat_q;

endmodule

`default_nettype wire

/* sv/swept_box_collision_time.sv */
// Top level of the swept box collision time block (slab test on two axes).
// Depends on sbct_pkg and sbct_div_cell.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one box pair per cycle while in_stall_o is low and returns
// one result per pair, in order, from the output register.
// The four axis times come from four chains of 49 division cells, one
// quotient bit per cell, followed by a saturation stage and the output
// register. A stall on the output freezes the whole pipeline, so the input
// stalls only while a finished result is held and the output is stalled.
module swept_box_collision_time
  import sbct_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire  [DW-1:0]     self_left_i,
  input  wire  [DW-1:0]     self_right_i,
  input  wire  [DW-1:0]     self_top_i,
  input  wire  [DW-1:0]     self_bottom_i,
  input  wire  [DW-1:0]     other_left_i,
  input  wire  [DW-1:0]     other_right_i,
  input  wire  [DW-1:0]     other_top_i,
  input  wire  [DW-1:0]     other_bottom_i,
  input  wire  [DW-1:0]     vel_x_i,
  input  wire  [DW-1:0]     vel_y_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic              hit_o,
  output logic [DW-1:0]     start_time_o,
  output logic [DW-1:0]     end_time_o,
  output logic [2:0]        hit_side_o
);

  logic en;
  logic out_valid_q;
  assign en = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Edge gaps, exact in 33 bits.
  logic [DW:0] gxa, gxb, gya, gyb;
  assign gxa = {self_left_i[DW-1], self_left_i} - {other_right_i[DW-1], other_right_i};
  assign gxb = {self_right_i[DW-1], self_right_i} - {other_left_i[DW-1], other_left_i};
  assign gya = {self_top_i[DW-1], self_top_i} - {other_bottom_i[DW-1], other_bottom_i};
  assign gyb = {self_bottom_i[DW-1], self_bottom_i} - {other_top_i[DW-1], other_top_i};

  function automatic logic [DW:0] mag33(input logic [DW:0] g);
    mag33 = g[DW] ? (~g + {{DW{1'b0}}, 1'b1}) : g;
  endfunction

  function automatic div_t mk_div(input logic [DW:0] g, input logic [DW-1:0] v);
    div_t r;
    r.rem = '0;
    r.nq  = {mag33(g), {(NW-DW-1){1'b0}}};
    r.d   = v[DW-1] ? (~v + {{(DW-1){1'b0}}, 1'b1}) : v;
    r.neg = g[DW] ^ v[DW-1];
    mk_div = r;
  endfunction

  info_t in_info;
  logic  x_zero, y_zero;
  always_comb begin
    x_zero = (vel_x_i == '0);
    y_zero = (vel_y_i == '0);
    in_info.x_pos = !x_zero && !vel_x_i[DW-1];
    in_info.x_neg = vel_x_i[DW-1];
    in_info.x_ovl = ($signed(self_left_i) < $signed(other_right_i)) &&
                    ($signed(self_right_i) > $signed(other_left_i));
    in_info.y_pos = !y_zero && !vel_y_i[DW-1];
    in_info.y_neg = vel_y_i[DW-1];
    in_info.y_ovl = ($signed(self_top_i) < $signed(other_bottom_i)) &&
                    ($signed(self_bottom_i) > $signed(other_top_i));
  end

  // Chains: 0 entry x, 1 exit x, 2 entry y, 3 exit y.
  div_t chain [4][NSTEP+1];

  // A negative velocity swaps which gap gives entry and which gives exit.
  assign chain[0][0] = mk_div(vel_x_i[DW-1] ? gxb : gxa, vel_x_i);
  assign chain[1][0] = mk_div(vel_x_i[DW-1] ? gxa : gxb, vel_x_i);
  assign chain[2][0] = mk_div(vel_y_i[DW-1] ? gyb : gya, vel_y_i);
  assign chain[3][0] = mk_div(vel_y_i[DW-1] ? gya : gyb, vel_y_i);

  for (genvar c = 0; c < 4; c++) begin : g_chain
    for (genvar s = 0; s < NSTEP; s++) begin : g_cell
      sbct_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .dat_i (chain[c][s]),
        .dat_o (chain[c][s+1])
      );
    end
  end

  // Side information and valid travel beside the division cells.
  info_t info_q  [NSTEP];
  logic  valid_q [NSTEP];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSTEP; i++) valid_q[i] <= 1'b0;
    end else if (en) begin
      valid_q[0] <= in_valid_i;
      for (int i = 1; i < NSTEP; i++) valid_q[i] <= valid_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      info_q[0] <= in_info;
      for (int i = 1; i < NSTEP; i++) info_q[i] <= info_q[i-1];
    end
  end

  // Saturation stage.
  logic signed [DW-1:0] sx_q, ex_q, sy_q, ey_q;
  info_t                post_info_q;
  logic                 post_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) post_valid_q <= 1'b0;
    else if (en) post_valid_q <= valid_q[NSTEP-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q <= sat_time(chain[0][NSTEP].nq, chain[0][NSTEP].neg);
      ex_q <= sat_time(chain[1][NSTEP].nq, chain[1][NSTEP].neg);
      sy_q <= sat_time(chain[2][NSTEP].nq, chain[2][NSTEP].neg);
      ey_q <= sat_time(chain[3][NSTEP].nq, chain[3][NSTEP].neg);
      post_info_q <= info_q[NSTEP-1];
    end
  end

  // Combine the two axes.
  logic signed [DW-1:0] sx, ex, sy, ey, s_t, e_t;
  logic                 hit_d;
  logic signed [DW-1:0] start_d, end_d;
  logic [2:0]           side_x, side_d;

  always_comb begin
    side_x = post_info_q.x_pos ? SIDE_LEFT : (post_info_q.x_neg ? SIDE_RIGHT : SIDE_NONE);
    if (post_info_q.x_pos || post_info_q.x_neg) begin
      sx = sx_q;
      ex = ex_q;
    end else begin
      sx = TIME_MIN;
      ex = TIME_MAX;
    end
    if (post_info_q.y_pos || post_info_q.y_neg) begin
      sy = sy_q;
      ey = ey_q;
    end else begin
      sy = TIME_MIN;
      ey = TIME_MAX;
    end
    s_t = (sx > sy) ? sx : sy;
    e_t = (ex < ey) ? ex : ey;
    side_d = side_x;
    if (post_info_q.y_pos && (sy >= sx)) side_d = SIDE_BOTTOM;
    if (post_info_q.y_neg && (sy >= sx)) side_d = SIDE_TOP;
    hit_d   = (s_t < e_t);
    start_d = s_t;
    end_d   = e_t;
    if (!post_info_q.x_pos && !post_info_q.x_neg && !post_info_q.x_ovl) begin
      hit_d   = 1'b0;
      start_d = '0;
      end_d   = '0;
      side_d  = SIDE_NONE;
    end else if (!post_info_q.y_pos && !post_info_q.y_neg && !post_info_q.y_ovl) begin
      hit_d   = 1'b0;
      start_d = '0;
      end_d   = '0;
      side_d  = side_x;
    end
  end

  logic                 hit_q;
  logic signed [DW-1:0] start_q, end_q;
  logic [2:0]           side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= post_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q   <= hit_d;
      start_q <= start_d;
      end_q   <= end_d;
      side_q  <= side_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign start_time_o = start_q;
  assign end_time_o   = end_q;
  assign hit_side_o   = side_q;

endmodule

`default_nettype wire

/* test/tb_swept_box_collision_time.sv */
// Testbench for swept_box_collision_time: random and directed box pairs with a
// scoreboard that predicts hit, entry/exit times and struck side.
// Depends on sbct_pkg and the swept_box_collision_time RTL.
`timescale 1ns / 1ps

module tb_swept_box_collision_time;
  import sbct_pkg::*;

  typedef struct packed {
    logic          hit;
    logic [31:0]   t_start;
    logic [31:0]   t_end;
    logic [2:0]    side;
  } hit_rec_t;

  typedef struct {
    logic signed [31:0] sl, sr, st, sb, ol, orr, ot, ob, vx, vy;
  } box_pair_t;

  class collision_scoreboard;
    hit_rec_t pending_hits[$];
    int       n_errors;
    int       n_checked;
    int       n_hits;

    function new();
      n_errors = 0;
      n_checked = 0;
      n_hits = 0;
    endfunction

    // Q16.16 time: (gap << 16) / vel, truncated toward zero, saturated.
    function longint slab_time(longint gap, longint vel);
      longint q;
      q = (gap * 65536) / vel;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      return q;
    endfunction

    function void note_pair(box_pair_t p);
      longint sx, ex, sy, ey, s, e;
      logic [2:0] side;
      hit_rec_t r;
      side = SIDE_NONE;
      r = '0;
      if (p.vx > 0) begin
        sx = slab_time(longint'(p.sl) - p.orr, p.vx);
        ex = slab_time(longint'(p.sr) - p.ol, p.vx);
        side = SIDE_LEFT;
      end else if (p.vx < 0) begin
        sx = slab_time(longint'(p.sr) - p.ol, p.vx);
        ex = slab_time(longint'(p.sl) - p.orr, p.vx);
        side = SIDE_RIGHT;
      end else if (p.sl < p.orr && p.sr > p.ol) begin
        sx = -64'sd2147483648;
        ex = 64'sd2147483647;
      end else begin
        pending_hits.push_back(r);
        return;
      end
      if (p.vy > 0) begin
        sy = slab_time(longint'(p.st) - p.ob, p.vy);
        ey = slab_time(longint'(p.sb) - p.ot, p.vy);
        if (sy >= sx) side = SIDE_BOTTOM;
      end else if (p.vy < 0) begin
        sy = slab_time(longint'(p.sb) - p.ot, p.vy);
        ey = slab_time(longint'(p.st) - p.ob, p.vy);
        if (sy >= sx) side = SIDE_TOP;
      end else if (p.st < p.ob && p.sb > p.ot) begin
        sy = -64'sd2147483648;
        ey = 64'sd2147483647;
      end else begin
        r.side = side;
        pending_hits.push_back(r);
        return;
      end
      s = (sx > sy) ? sx : sy;
      e = (ex < ey) ? ex : ey;
      r.hit = (s < e);
      r.t_start = s[31:0];
      r.t_end = e[31:0];
      r.side = side;
      pending_hits.push_back(r);
    endfunction

    function void check_result(hit_rec_t got);
      hit_rec_t exp_r;
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        n_errors++;
        return;
      end
      exp_r = pending_hits.pop_front();
      n_checked++;
      if (got.hit) n_hits++;
      if (got.hit !== exp_r.hit) begin
        $display("%0t: hit expected %0b actual %0b", $time, exp_r.hit, got.hit);
        n_errors++;
      end
      if (got.t_start !== exp_r.t_start) begin
        $display("%0t: start_time expected %h actual %h", $time, exp_r.t_start, got.t_start);
        n_errors++;
      end
      if (got.t_end !== exp_r.t_end) begin
        $display("%0t: end_time expected %h actual %h", $time, exp_r.t_end, got.t_end);
        n_errors++;
      end
      if (got.side !== exp_r.side) begin
        $display("%0t: hit_side expected %0d actual %0d", $time, exp_r.side, got.side);
        n_errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1300;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] self_left_i, self_right_i, self_top_i, self_bottom_i;
  logic [31:0] other_left_i, other_right_i, other_top_i, other_bottom_i;
  logic [31:0] vel_x_i, vel_y_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        hit_o;
  logic [31:0] start_time_o, end_time_o;
  logic [2:0]  hit_side_o;

  collision_scoreboard sb_q;
  int idle_cycles;
  int n_sent;
  bit timed_out;

  swept_box_collision_time i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .self_left_i, .self_right_i, .self_top_i, .self_bottom_i,
    .other_left_i, .other_right_i, .other_top_i, .other_bottom_i,
    .vel_x_i, .vel_y_i,
    .out_valid_o, .out_stall_i, .hit_o, .start_time_o, .end_time_o, .hit_side_o
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Receiver stall pattern: alternating quiet and busy stretches.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (($time / 12000) % 3 == 0) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb_q.check_result('{hit_o, start_time_o, end_time_o, hit_side_o});
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_edge();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return $signed($urandom_range(0, 32'h0028_0000)) - 32'sh0014_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(0, 7))
      0, 1: return 32'h0;
      2: return $urandom;
      3: return ($urandom_range(0, 1)) ? 32'h8000_0000 : 32'h7fff_ffff;
      4: return $signed($urandom_range(0, 8)) - 4;
      default: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endcase
  endfunction

  // Mostly ordered boxes in a common region so hits and late misses occur.
  function automatic box_pair_t rand_pair();
    box_pair_t p;
    logic signed [31:0] w;
    if ($urandom_range(0, 4) == 0) begin
      p.sl = rand_edge(); p.sr = rand_edge(); p.st = rand_edge(); p.sb = rand_edge();
      p.ol = rand_edge(); p.orr = rand_edge(); p.ot = rand_edge(); p.ob = rand_edge();
    end else begin
      p.sl = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      w = $urandom_range(1, 32'h0004_0000); p.sr = p.sl + w;
      p.st = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      w = $urandom_range(1, 32'h0004_0000); p.sb = p.st + w;
      p.ol = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      w = $urandom_range(1, 32'h0004_0000); p.orr = p.ol + w;
      p.ot = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      w = $urandom_range(1, 32'h0004_0000); p.ob = p.ot + w;
    end
    p.vx = rand_vel();
    p.vy = rand_vel();
    return p;
  endfunction

  // Drives one pair and holds it until the transfer.
  task automatic send_pair(box_pair_t p);
    in_valid_i <= 1'b1;
    self_left_i <= p.sl;  self_right_i <= p.sr;
    self_top_i <= p.st;   self_bottom_i <= p.sb;
    other_left_i <= p.ol; other_right_i <= p.orr;
    other_top_i <= p.ot;  other_bottom_i <= p.ob;
    vel_x_i <= p.vx;      vel_y_i <= p.vy;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb_q.note_pair(p);
    n_sent++;
  endtask

  task automatic idle_gap(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic box_pair_t mk(int sl, int sr, int st, int sb, int ol, int orr,
                                   int ot, int ob, int vx, int vy);
    box_pair_t p;
    p.sl = sl; p.sr = sr; p.st = st; p.sb = sb;
    p.ol = ol; p.orr = orr; p.ot = ot; p.ob = ob;
    p.vx = vx; p.vy = vy;
    return p;
  endfunction

  initial begin
    box_pair_t dir_q[$];
    int burst;
    sb_q = new();
    n_sent = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    {self_left_i, self_right_i, self_top_i, self_bottom_i} = '0;
    {other_left_i, other_right_i, other_top_i, other_bottom_i} = '0;
    {vel_x_i, vel_y_i} = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: moving right/left/up/down, overlap at rest, early misses on
    // each axis, late miss, saturation and the field extremes.
    dir_q.push_back(mk(0, 'h10000, 0, 'h10000, 'h30000, 'h40000, 0, 'h10000, 'h10000, 0));
    dir_q.push_back(mk('h30000, 'h40000, 0, 'h10000, 0, 'h10000, 0, 'h10000, -'h10000, 0));
    dir_q.push_back(mk(0, 'h10000, 0, 'h10000, 0, 'h10000, 'h30000, 'h40000, 0, 'h10000));
    dir_q.push_back(mk(0, 'h10000, 'h30000, 'h40000, 0, 'h10000, 0, 'h10000, 0, -'h10000));
    dir_q.push_back(mk(0, 'h10000, 0, 'h10000, 0, 'h10000, 0, 'h10000, 0, 0));
    dir_q.push_back(mk(0, 'h10000, 0, 'h10000, 'h10000, 'h20000, 0, 'h10000, 0, 0));
    dir_q.push_back(mk(0, 'h10000, 0, 'h10000, 'h30000, 'h40000, 'h10000, 'h20000, 'h10000, 0));
    dir_q.push_back(mk(0, 'h10000, 0, 'h10000, 0, 'h10000, 'h10000, 'h20000, -'h10000, 0));
    dir_q.push_back(mk(0, 'h10000, 0, 'h10000, 'h30000, 'h40000, 'h80000, 'h90000,
                       'h10000, 'h10000));
    dir_q.push_back(mk(0, 'h10000, 0, 'h10000, 'h20000, 'h30000, 'h20000, 'h30000,
                       'h10000, 'h10000));
    dir_q.push_back(mk(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                       32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 1, -1));
    dir_q.push_back(mk(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                       32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                       32'sh8000_0000, 32'sh7fff_ffff));
    dir_q.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    dir_q.push_back(mk(0, 'h10000, 0, 'h10000, 'h20000, 'h30000, 0, 'h10000, 1, 0));
    dir_q.push_back(mk(0, 'h10000, 0, 'h10000, 'h20000, 'h30000, 0, 'h10000,
                       32'sh8000_0000, 32'sh7fff_ffff));
    foreach (dir_q[i]) send_pair(dir_q[i]);

    // Hold off until the pipeline has drained once.
    in_valid_i <= 1'b0;
    while (sb_q.pending_hits.size() != 0) @(posedge clk_i);

    while (n_sent < dir_q.size() + N_RANDOM) begin
      burst = $urandom_range(1, 40);
      repeat (burst) send_pair(rand_pair());
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
    end
    in_valid_i <= 1'b0;

    while (sb_q.pending_hits.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("Sent %0d box pairs, checked %0d results, %0d of them hits.",
             n_sent, sb_q.n_checked, sb_q.n_hits);
    if (sb_q.n_errors == 0 && sb_q.pending_hits.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/sbct_pkg.sv
sv/sbct_div_cell.sv
sv/swept_box_collision_time.sv
test/tb_swept_box_collision_time.sv
